// ===== design/tdpt_pkg.sv =====
// Shared types, constants and the microcode program of the trial division prime test.
// Used by tdpt_div, tdpt_seq and trial_division_prime_test; depends on nothing.
package tdpt_pkg;

    localparam int VALUE_BITS = 32;
    // A trial divisor never exceeds floor(sqrt(2^(VALUE_BITS-1))) + 2.
    localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
    localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int PC_W       = 5;
    localparam int CONST_W    = 4;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [DIV_BITS-1:0]   divisor_t;
    typedef logic [PC_W-1:0]       pc_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV_CONST,
        ACT_DIV_NEXT,
        ACT_WRITE1,
        ACT_WRITE0
    } act_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_SMALL_NONPRIME,
        C_SMALL_PRIME,
        C_EVEN,
        C_DIV_BUSY,
        C_REM_ZERO,
        C_Q_LT_D,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t               act;
        cond_t              cond;
        pc_t                target;
        logic [CONST_W-1:0] dconst;
    } ctrl_word_t;

    // Datapath status that the sequencer tests for its jumps.
    typedef struct packed {
        logic no_input;
        logic small_nonprime;
        logic small_prime;
        logic even;
        logic div_busy;
        logic rem_zero;
        logic q_lt_d;
        logic out_busy;
    } flags_t;

    localparam pc_t S_IDLE       = 5'd0;
    localparam pc_t S_SMALL_NP   = 5'd1;
    localparam pc_t S_SMALL_P    = 5'd2;
    localparam pc_t S_EVEN       = 5'd3;
    localparam pc_t S_D3         = 5'd4;
    localparam pc_t S_LOOP_WAIT  = 5'd5;
    localparam pc_t S_LOOP_BOUND = 5'd6;
    localparam pc_t S_LOOP_REM   = 5'd7;
    localparam pc_t S_LOOP_NEXT  = 5'd8;
    localparam pc_t S_TRUE_WAIT  = 5'd9;
    localparam pc_t S_TRUE_PUT   = 5'd10;
    localparam pc_t S_FALSE_WAIT = 5'd11;
    localparam pc_t S_FALSE_PUT  = 5'd12;

    function automatic ctrl_word_t cw(act_t act, cond_t cond, pc_t target,
                                      logic [CONST_W-1:0] dconst);
        ctrl_word_t w;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        w.dconst = dconst;
        return w;
    endfunction

    // Microcode program. A word performs its action, then jumps to its target when its
    // condition holds and otherwise falls through to the next step.
    // Odd divisors run from 3 upward, so divisibility by 3, 5 and 7 falls out of the loop.
    function automatic ctrl_word_t rom_word(pc_t pc);
        ctrl_word_t w;
        w = cw(ACT_NONE, C_ALWAYS, S_IDLE, 4'd0);
        unique case (pc)
            S_IDLE:       w = cw(ACT_LOAD,      C_NO_INPUT,       S_IDLE,       4'd0);
            S_SMALL_NP:   w = cw(ACT_NONE,      C_SMALL_NONPRIME, S_FALSE_WAIT, 4'd0);
            S_SMALL_P:    w = cw(ACT_NONE,      C_SMALL_PRIME,    S_TRUE_WAIT,  4'd0);
            S_EVEN:       w = cw(ACT_NONE,      C_EVEN,           S_FALSE_WAIT, 4'd0);
            S_D3:         w = cw(ACT_DIV_CONST, C_NEVER,          S_IDLE,       4'd3);
            S_LOOP_WAIT:  w = cw(ACT_NONE,      C_DIV_BUSY,       S_LOOP_WAIT,  4'd0);
            S_LOOP_BOUND: w = cw(ACT_NONE,      C_Q_LT_D,         S_TRUE_WAIT,  4'd0);
            S_LOOP_REM:   w = cw(ACT_NONE,      C_REM_ZERO,       S_FALSE_WAIT, 4'd0);
            S_LOOP_NEXT:  w = cw(ACT_DIV_NEXT,  C_ALWAYS,         S_LOOP_WAIT,  4'd0);
            S_TRUE_WAIT:  w = cw(ACT_NONE,      C_OUT_BUSY,       S_TRUE_WAIT,  4'd0);
            S_TRUE_PUT:   w = cw(ACT_WRITE1,    C_ALWAYS,         S_IDLE,       4'd0);
            S_FALSE_WAIT: w = cw(ACT_NONE,      C_OUT_BUSY,       S_FALSE_WAIT, 4'd0);
            S_FALSE_PUT:  w = cw(ACT_WRITE0,    C_ALWAYS,         S_IDLE,       4'd0);
            default:      w = cw(ACT_NONE,      C_ALWAYS,         S_IDLE,       4'd0);
        endcase
        return w;
    endfunction

endpackage

// ===== design/tdpt_div.sv =====
// Restoring divider of the trial division prime test: one quotient bit per cycle.
// Depends on tdpt_pkg for the value and divisor widths.
module tdpt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tdpt_pkg::value_t   dividend,
    input  tdpt_pkg::divisor_t divisor,
    output logic              busy,
    output tdpt_pkg::value_t   quotient,
    output tdpt_pkg::divisor_t remainder
);
    import tdpt_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    value_t            quo_reg, quo_next;
    divisor_t          rem_reg, rem_next;
    divisor_t          dvs_reg, dvs_next;
    logic [DIV_BITS:0]   rem_sh;
    logic [DIV_BITS+1:0] diff;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dvs_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(VALUE_BITS);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            // A clear top bit of the difference means the shifted remainder covers the divisor.
            if (!diff[DIV_BITS+1])
            begin
                rem_next = diff[DIV_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIV_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (cnt_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/tdpt_seq.sv =====
// Microcode sequencer of the trial division prime test: step counter, program table
// lookup and conditional jumps. Depends on tdpt_pkg for the program and its types.
module tdpt_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdpt_pkg::flags_t     flags,
    output tdpt_pkg::ctrl_word_t ctrl
);
    import tdpt_pkg::*;

    pc_t        pc_reg, pc_next;
    ctrl_word_t word;
    logic       take;

    always_comb
    begin
        word = rom_word(pc_reg);
        unique case (word.cond)
            C_NEVER:          take = 1'b0;
            C_ALWAYS:         take = 1'b1;
            C_NO_INPUT:       take = flags.no_input;
            C_SMALL_NONPRIME: take = flags.small_nonprime;
            C_SMALL_PRIME:    take = flags.small_prime;
            C_EVEN:           take = flags.even;
            C_DIV_BUSY:       take = flags.div_busy;
            C_REM_ZERO:       take = flags.rem_zero;
            C_Q_LT_D:         take = flags.q_lt_d;
            C_OUT_BUSY:       take = flags.out_busy;
            default:          take = 1'b1;
        endcase
        pc_next = take ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

// ===== design/trial_division_prime_test.sv =====
// Trial division prime test: one signed word in, one word out saying whether it is prime.
// A small microcoded sequencer drives one shared restoring divider that yields one quotient
// bit per cycle. Negative values and values below 2 are rejected, 2, 3, 5 and 7 are accepted,
// and other even values are rejected from the low bit; odd values then try odd divisors from
// 3 upward, each trial being a divider start, a wait on the divider, a bound test and a
// remainder test. The bound test accepts the value as prime once the quotient falls below the
// divisor, and the remainder test rejects it when the remainder is zero. The block takes a new
// word once the result of the previous one is held in the output register. A result waits
// while the previous one is still held unread. Depends on tdpt_pkg, tdpt_seq and tdpt_div.
module trial_division_prime_test (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [tdpt_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // candidate
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [tdpt_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // is_prime, then zeros
);
    import tdpt_pkg::*;

    ctrl_word_t ctrl;
    flags_t     flags;
    value_t     v_reg, v_next;
    divisor_t   d_reg, d_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_bit_reg, out_bit_next;
    logic       div_start;
    logic       div_busy;
    value_t     quotient;
    divisor_t   remainder;

    tdpt_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    tdpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (v_reg),
        .divisor   (d_next),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign s_axis_tready = (ctrl.act == ACT_LOAD);

    always_comb
    begin
        v_next         = v_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_bit_next   = out_bit_reg;
        div_start      = 1'b0;
        unique case (ctrl.act)
            ACT_NONE:
            begin
            end
            ACT_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    v_next = s_axis_tdata[VALUE_BITS-1:0];
                end
            end
            ACT_DIV_CONST:
            begin
                d_next    = DIV_BITS'(ctrl.dconst);
                div_start = 1'b1;
            end
            ACT_DIV_NEXT:
            begin
                d_next    = d_reg + DIV_BITS'(2);
                div_start = 1'b1;
            end
            ACT_WRITE1:
            begin
                out_valid_next = 1'b1;
                out_bit_next   = 1'b1;
            end
            ACT_WRITE0:
            begin
                out_valid_next = 1'b1;
                out_bit_next   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // The top bit of the word is the sign; negative values are never prime.
    always_comb
    begin
        flags.no_input       = !s_axis_tvalid;
        flags.small_nonprime = v_reg[VALUE_BITS-1] || (v_reg <= VALUE_BITS'(1));
        flags.small_prime    = (v_reg == VALUE_BITS'(2)) || (v_reg == VALUE_BITS'(3))
                            || (v_reg == VALUE_BITS'(5)) || (v_reg == VALUE_BITS'(7));
        flags.even           = !v_reg[0];
        flags.div_busy       = div_busy;
        flags.rem_zero       = (remainder == '0);
        flags.q_lt_d         = (quotient < VALUE_BITS'(d_reg));
        flags.out_busy       = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        d_reg       <= d_next;
        out_bit_reg <= out_bit_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_bit_reg};

`ifndef ASSERT_OFF
    a_no_load_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !s_axis_tready)
        else $error("input accepted while the divider is busy");

    a_no_restart_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted before it finished");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_WRITE1 || ctrl.act == ACT_WRITE0) |-> !out_valid_reg)
        else $error("result written over one not yet taken");

    a_divisor_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_DIV_NEXT) |=> (d_reg == $past(d_reg) + DIV_BITS'(2)))
        else $error("trial divisor did not step by two");
`endif

endmodule
